[rtl/fraa_pkg.sv]
package fraa_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_W     = 10;
  localparam int SUM_W        = SAMPLE_W + PTR_W;
  localparam int PROD_W       = 20;
  localparam int RECIP_SH     = PROD_W + 10;
  localparam int RECIP_W      = 27;
  localparam int QUOT_W       = PROD_W + RECIP_W - RECIP_SH;
  localparam int FIXED_W      = 10;
  localparam int WHOLE_W      = 6;
  localparam int HUND_W       = 7;
  localparam int RANGE_W      = 2;
  localparam int REQ_W        = 2;
  localparam int S_DATA_W     = 16;
  localparam int M_DATA_W     = 32;

  localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BUTTON  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd2;

  localparam int Den0 = 254;
  localparam int Den1 = 17;
  localparam int Den2 = 819;
  localparam int Den3 = 427;

  localparam logic [SAMPLE_W-1:0] OFFSET_TAB [4] = '{10'd516, 10'd344, 10'd205, 10'd170};
  localparam logic [9:0]          NUM_TAB    [4] = '{10'd80, 10'd8, 10'd640, 10'd400};
  localparam logic [WHOLE_W-1:0]  LIMIT_TAB  [4] = '{6'd9, 6'd18, 6'd36, 6'd45};

  // ceil(2^RECIP_SH / den), exact floor division for products below 2^PROD_W
  localparam logic [RECIP_W-1:0] RECIP_TAB [4] = '{
    RECIP_W'(((2 ** RECIP_SH) + Den0 - 1) / Den0),
    RECIP_W'(((2 ** RECIP_SH) + Den1 - 1) / Den1),
    RECIP_W'(((2 ** RECIP_SH) + Den2 - 1) / Den2),
    RECIP_W'(((2 ** RECIP_SH) + Den3 - 1) / Den3)
  };

  typedef struct packed {
    logic take_sample;
    logic advance;
  } st_cmd_t;

  typedef struct packed {
    logic [FIXED_W-1:0] fixed;
    logic [WHOLE_W-1:0] whole;
    logic [HUND_W-1:0]  hund;
    logic [RANGE_W-1:0] rng;
    logic               over;
  } result_t;

  // nibble * 100 / 16
  function automatic logic [HUND_W-1:0] hund_f(input logic [3:0] n);
    logic [10:0] w;
    w = {1'b0, n, 6'b0} + {2'b0, n, 5'b0} + {5'b0, n, 2'b0};
    return w[10:4];
  endfunction

endpackage

[rtl/four_range_ammeter_averager.sv]
// current meter front end with an 8-sample moving average and four ranges
// slave channel: one word per item; tuser carries the request kind
// (sample, button, measure), tdata carries the sample and the button level
// sample words update the ring and running sum, button words with level 1
// step the range 10A -> 20A -> 40A -> 50A -> 10A; neither gives a result
// a measure word gives one master word: amps in 6.4 fixed point, whole amps,
// hundredths, active range and an over-range flag
// pipeline: input register, product register, output register; a measure
// result passes through them in that order to the master side
// throughput is one word per cycle while the receiver keeps up, set by the
// state update and the one multiplier in each of the two scaling stages
// a stalled receiver holds the output word; sample and button words keep
// flowing, measure words fill the product and output registers and a third
// measure word then waits in the input register with tready low
// reset clears the ring, the sum, the pointer, the range (10A) and all valid
// flags; words are accepted from the first edge after reset release
module four_range_ammeter_averager (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [9:0] sample, [10] button_level
  input  logic [fraa_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [fraa_pkg::REQ_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [9:0] amps_fixed, [15:10] amps_whole, [22:16] amps_hundredths,
  // [24:23] range_index, [25] over_range
  output logic [fraa_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import fraa_pkg::*;

  logic                in_vld_q;
  logic [REQ_W-1:0]    in_req_q;
  logic [SAMPLE_W-1:0] in_smp_q;
  logic                in_lvl_q;
  logic                mid_vld_q;
  logic                out_vld_q;
  result_t             out_res_q;
  result_t             res;
  st_cmd_t             cmd;
  logic [SUM_W-1:0]    sum;
  logic [RANGE_W-1:0]  rng;
  logic                out_free, mid_free, in_fire, in_take, mid_load;

  always_comb begin
    out_free = !out_vld_q || m_axis_tready;
    mid_free = !mid_vld_q || out_free;
    in_fire  = in_vld_q && ((in_req_q != REQ_MEASURE) || mid_free);
    mid_load = in_fire && (in_req_q == REQ_MEASURE);
    in_take  = s_axis_tvalid && s_axis_tready;
    cmd.take_sample = in_fire && (in_req_q == REQ_SAMPLE);
    cmd.advance     = in_fire && (in_req_q == REQ_BUTTON) && in_lvl_q;
  end

  assign s_axis_tready = !in_vld_q || in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (mid_free) mid_vld_q <= mid_load;
      if (out_free) out_vld_q <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= s_axis_tuser;
      in_smp_q <= s_axis_tdata[SAMPLE_W-1:0];
      in_lvl_q <= s_axis_tdata[SAMPLE_W];
    end
    if (out_free && mid_vld_q) begin
      out_res_q <= res;
    end
  end

  fraa_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sample_i (in_smp_q),
    .sum_o    (sum),
    .range_o  (rng)
  );

  fraa_scale u_scale (
    .clk_i   (clk_i),
    .load_i  (mid_load),
    .sum_i   (sum),
    .range_i (rng),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_res_q.over, out_res_q.rng, out_res_q.hund,
                          out_res_q.whole, out_res_q.fixed};

endmodule

[rtl/fraa_state.sv]
module fraa_state (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fraa_pkg::st_cmd_t         cmd_i,
  input  logic [fraa_pkg::SAMPLE_W-1:0] sample_i,
  output logic [fraa_pkg::SUM_W-1:0]    sum_o,
  output logic [fraa_pkg::RANGE_W-1:0]  range_o
);
  import fraa_pkg::*;

  logic [SAMPLE_W-1:0] ring_q [WINDOW_DEPTH];
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [RANGE_W-1:0]  range_q;

  always_comb begin
    sum_d = sum_q - SUM_W'(ring_q[ptr_q]) + SUM_W'(sample_i);
    if (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) ring_q[k] <= '0;
      ptr_q   <= '0;
      sum_q   <= '0;
      range_q <= '0;
    end else begin
      if (cmd_i.take_sample) begin
        ring_q[ptr_q] <= sample_i;
        ptr_q         <= ptr_d;
        sum_q         <= sum_d;
      end
      if (cmd_i.advance) begin
        range_q <= range_q + RANGE_W'(1);
      end
    end
  end

  assign sum_o   = sum_q;
  assign range_o = range_q;

endmodule

[rtl/fraa_scale.sv]
module fraa_scale (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic [fraa_pkg::SUM_W-1:0]   sum_i,
  input  logic [fraa_pkg::RANGE_W-1:0] range_i,
  output fraa_pkg::result_t            res_o
);
  import fraa_pkg::*;

  logic [SAMPLE_W-1:0]        avg;
  logic [SAMPLE_W-1:0]        above;
  logic [PROD_W-1:0]          prod_d, prod_q;
  logic [RANGE_W-1:0]         rng_q;
  logic [PROD_W+RECIP_W-1:0]  wide;
  logic [QUOT_W-1:0]          quot;
  logic [FIXED_W-1:0]         fixed;

  // offset removal saturates at zero
  always_comb begin
    avg    = SAMPLE_W'(sum_i / WINDOW_DEPTH);
    above  = (avg > OFFSET_TAB[range_i]) ? (avg - OFFSET_TAB[range_i]) : '0;
    prod_d = PROD_W'(above * NUM_TAB[range_i]);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      rng_q  <= range_i;
    end
  end

  always_comb begin
    wide  = PROD_W'(0) + (PROD_W + RECIP_W)'(prod_q) * (PROD_W + RECIP_W)'(RECIP_TAB[rng_q]);
    quot  = wide[PROD_W+RECIP_W-1:RECIP_SH];
    fixed = (quot > QUOT_W'(2 ** FIXED_W - 1)) ? '1 : quot[FIXED_W-1:0];
    res_o.fixed = fixed;
    res_o.whole = fixed[FIXED_W-1:4];
    res_o.hund  = hund_f(fixed[3:0]);
    res_o.rng   = rng_q;
    res_o.over  = (fixed[FIXED_W-1:4] >= LIMIT_TAB[rng_q]);
  end

endmodule
